/* sv/assert_macros.svh */
// Assertion macros for the module that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only while reset is released.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only while reset is released.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pgc_pkg.sv */
// Types, widths and status codes of the polygon centroid block.
package pgc_pkg;

    localparam int unsigned COORD_BITS   = 16;
    localparam int unsigned MAX_VERTICES = 4096;

    localparam int unsigned XY_W   = 16;
    localparam int unsigned CB     = COORD_BITS;
    localparam int unsigned CNT_W  = $clog2(MAX_VERTICES + 2);
    localparam int unsigned MA_W   = CB + 1;
    localparam int unsigned MB_W   = 2 * CB + 1;
    localparam int unsigned P_W    = MA_W + MB_W;
    localparam int unsigned AREA_W = 48;
    localparam int unsigned SUM_W  = 64;
    localparam int unsigned DEN_W  = AREA_W + 2;
    localparam int unsigned STEP_W = $clog2(SUM_W);

    localparam logic [SUM_W-1:0] Q_HI = SUM_W'((2 ** (CB - 1)) - 1);
    localparam logic signed [XY_W-1:0] OUT_HI = XY_W'((2 ** (CB - 1)) - 1);
    localparam logic signed [XY_W-1:0] OUT_LO = XY_W'(-(2 ** (CB - 1)));

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SINGLE    = 2'd1,
        ST_ZERO_AREA = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [XY_W-1:0] vertex_x;
        logic signed [XY_W-1:0] vertex_y;
        logic                   last_vertex;
    } t_in;

    typedef struct packed {
        logic signed [XY_W-1:0] centroid_x;
        logic signed [XY_W-1:0] centroid_y;
        t_status                status;
    } t_out;

endpackage

/* sv/pgc_mul.sv */
// Shared signed multiplier with a registered product.
module pgc_mul (
    input  logic                             i_clk,
    input  logic signed [pgc_pkg::MA_W-1:0]  i_a,
    input  logic signed [pgc_pkg::MB_W-1:0]  i_b,
    output logic signed [pgc_pkg::P_W-1:0]   o_p
);

    logic signed [pgc_pkg::P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= pgc_pkg::P_W'(i_a) * pgc_pkg::P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

/* sv/pgc_div.sv */
// Bit-serial restoring divider with truncation toward zero and output saturation.
module pgc_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [pgc_pkg::SUM_W-1:0]  i_num,
    input  logic signed [pgc_pkg::DEN_W-1:0]  i_den,
    output logic                              o_done,
    output logic signed [pgc_pkg::XY_W-1:0]   o_quo
);

    localparam logic [pgc_pkg::STEP_W-1:0] LAST_STEP = pgc_pkg::STEP_W'(pgc_pkg::SUM_W - 1);

    logic                          r_busy;
    logic                          r_done;
    logic [pgc_pkg::STEP_W-1:0]    r_cnt;
    logic [pgc_pkg::DEN_W-1:0]     r_rem;
    logic [pgc_pkg::DEN_W-1:0]     r_dm;
    logic [pgc_pkg::SUM_W-1:0]     r_quo;
    logic                          r_neg;

    logic [pgc_pkg::DEN_W:0]       w_trial;
    logic [pgc_pkg::DEN_W:0]       w_diff;
    logic                          w_ge;

    assign w_trial = {r_rem, r_quo[pgc_pkg::SUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dm};
    assign w_diff  = w_trial - {1'b0, r_dm};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_num[pgc_pkg::SUM_W-1] ? pgc_pkg::SUM_W'(-i_num)
                                                  : pgc_pkg::SUM_W'(i_num);
                r_dm   <= i_den[pgc_pkg::DEN_W-1] ? pgc_pkg::DEN_W'(-i_den)
                                                  : pgc_pkg::DEN_W'(i_den);
                r_neg  <= i_num[pgc_pkg::SUM_W-1] ^ i_den[pgc_pkg::DEN_W-1];
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[pgc_pkg::DEN_W-1:0] : w_trial[pgc_pkg::DEN_W-1:0];
                r_quo <= {r_quo[pgc_pkg::SUM_W-2:0], w_ge};
                r_cnt <= r_cnt + pgc_pkg::STEP_W'(1);
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (!r_neg) begin
            o_quo = (r_quo > pgc_pkg::Q_HI) ? pgc_pkg::OUT_HI
                                            : $signed(r_quo[pgc_pkg::XY_W-1:0]);
        end else begin
            o_quo = (r_quo > pgc_pkg::Q_HI + pgc_pkg::SUM_W'(1)) ? pgc_pkg::OUT_LO
                                            : -$signed(r_quo[pgc_pkg::XY_W-1:0]);
        end
    end

    assign o_done = r_done;

endmodule

/* sv/polygon_centroid.sv */
// Top level of the streaming polygon centroid by the shoelace formula.
// A vertex that opens a polygon is taken in S_IDLE alone; any other vertex that is not the last
// runs its edge through S_E1 to S_E6 before the next vertex is accepted, unless the polygon is overlong.
// The last vertex runs its edge and the closing one, then the x and y divider runs, before its result is presented,
// or goes from S_PREP straight to S_DONE on zero area; a single vertex or an overlong polygon goes
// straight to S_DONE. Synchronous active-low reset clears the sequencer, sums and output valid.
`include "assert_macros.svh"

module polygon_centroid (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  pgc_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output pgc_pkg::t_out  o_out_data
);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_E1   = 13'b0000000000010,
        S_E2   = 13'b0000000000100,
        S_E3   = 13'b0000000001000,
        S_E4   = 13'b0000000010000,
        S_E5   = 13'b0000000100000,
        S_E6   = 13'b0000001000000,
        S_PREP = 13'b0000010000000,
        S_DIVX = 13'b0000100000000,
        S_WX   = 13'b0001000000000,
        S_DIVY = 13'b0010000000000,
        S_WY   = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic signed [pgc_pkg::CB-1:0]     r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic signed [pgc_pkg::CB-1:0]     r_xa, r_ya, r_xb, r_yb;
    logic [pgc_pkg::CNT_W-1:0]         r_cnt;
    logic                              r_last;
    logic                              r_closing;
    logic signed [pgc_pkg::MB_W-1:0]   r_t;
    logic signed [pgc_pkg::MB_W-1:0]   r_c;
    logic signed [pgc_pkg::AREA_W-1:0] r_area;
    logic signed [pgc_pkg::SUM_W-1:0]  r_wsx, r_wsy;
    logic signed [pgc_pkg::DEN_W-1:0]  r_den;
    pgc_pkg::t_out                     r_res;
    pgc_pkg::t_out                     r_out;
    logic                              r_out_valid;

    logic                              w_in_acc;
    logic                              w_out_free;
    logic signed [pgc_pkg::CB-1:0]     w_x, w_y;
    logic signed [pgc_pkg::MA_W-1:0]   w_ma;
    logic signed [pgc_pkg::MB_W-1:0]   w_mb;
    logic signed [pgc_pkg::P_W-1:0]    w_p;
    logic signed [pgc_pkg::MB_W-1:0]   w_c;
    logic signed [pgc_pkg::DEN_W-1:0]  w_area_ext;
    logic                              w_div_start;
    logic signed [pgc_pkg::SUM_W-1:0]  w_div_num;
    logic                              w_div_done;
    logic signed [pgc_pkg::XY_W-1:0]   w_div_quo;

    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_x        = i_in_data.vertex_x[pgc_pkg::CB-1:0];
    assign w_y        = i_in_data.vertex_y[pgc_pkg::CB-1:0];
    assign w_c        = r_t - pgc_pkg::MB_W'(w_p);
    assign w_area_ext = pgc_pkg::DEN_W'(r_area);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_E1: begin
                w_ma = pgc_pkg::MA_W'(r_xa);
                w_mb = pgc_pkg::MB_W'(r_yb);
            end
            S_E2: begin
                w_ma = pgc_pkg::MA_W'(r_xb);
                w_mb = pgc_pkg::MB_W'(r_ya);
            end
            S_E4: begin
                w_ma = pgc_pkg::MA_W'(r_xa) + pgc_pkg::MA_W'(r_xb);
                w_mb = r_c;
            end
            S_E5: begin
                w_ma = pgc_pkg::MA_W'(r_ya) + pgc_pkg::MA_W'(r_yb);
                w_mb = r_c;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    pgc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_p)
    );

    assign w_div_start = (r_state == S_DIVX) || (r_state == S_DIVY);
    assign w_div_num   = (r_state == S_DIVY) ? r_wsy : r_wsx;

    pgc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (r_cnt == '0) begin
                        n_state = i_in_data.last_vertex ? S_DONE : S_IDLE;
                    end else if (r_cnt < pgc_pkg::CNT_W'(pgc_pkg::MAX_VERTICES)) begin
                        n_state = S_E1;
                    end else begin
                        n_state = i_in_data.last_vertex ? S_DONE : S_IDLE;
                    end
                end
            end
            S_E1:   n_state = S_E2;
            S_E2:   n_state = S_E3;
            S_E3:   n_state = S_E4;
            S_E4:   n_state = S_E5;
            S_E5:   n_state = S_E6;
            S_E6: begin
                if (r_closing) begin
                    n_state = S_PREP;
                end else if (r_last) begin
                    n_state = S_E1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PREP: n_state = (r_area == '0) ? S_DONE : S_DIVX;
            S_DIVX: n_state = S_WX;
            S_WX:   n_state = w_div_done ? S_DIVY : S_WX;
            S_DIVY: n_state = S_WY;
            S_WY:   n_state = w_div_done ? S_DONE : S_WY;
            S_DONE: n_state = w_out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_first_x   <= '0;
            r_first_y   <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_area      <= '0;
            r_wsx       <= '0;
            r_wsy       <= '0;
            r_last      <= 1'b0;
            r_closing   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_prev_x  <= w_x;
                        r_prev_y  <= w_y;
                        r_last    <= i_in_data.last_vertex;
                        r_closing <= 1'b0;
                        if (r_cnt == '0) begin
                            r_first_x <= w_x;
                            r_first_y <= w_y;
                            r_cnt     <= pgc_pkg::CNT_W'(1);
                            r_res.centroid_x <= pgc_pkg::XY_W'(w_x);
                            r_res.centroid_y <= pgc_pkg::XY_W'(w_y);
                            r_res.status     <= pgc_pkg::ST_SINGLE;
                        end else if (r_cnt < pgc_pkg::CNT_W'(pgc_pkg::MAX_VERTICES)) begin
                            r_xa  <= r_prev_x;
                            r_ya  <= r_prev_y;
                            r_xb  <= w_x;
                            r_yb  <= w_y;
                            r_cnt <= r_cnt + pgc_pkg::CNT_W'(1);
                        end else begin
                            r_cnt <= pgc_pkg::CNT_W'(pgc_pkg::MAX_VERTICES + 1);
                            r_res.centroid_x <= '0;
                            r_res.centroid_y <= '0;
                            r_res.status     <= pgc_pkg::ST_OVERFLOW;
                        end
                    end
                end
                S_E2: begin
                    r_t <= pgc_pkg::MB_W'(w_p);
                end
                S_E3: begin
                    r_c    <= w_c;
                    r_area <= r_area + pgc_pkg::AREA_W'(w_c);
                end
                S_E5: begin
                    r_wsx <= r_wsx + pgc_pkg::SUM_W'(w_p);
                end
                S_E6: begin
                    r_wsy <= r_wsy + pgc_pkg::SUM_W'(w_p);
                    if (!r_closing && r_last) begin
                        r_xa      <= r_prev_x;
                        r_ya      <= r_prev_y;
                        r_xb      <= r_first_x;
                        r_yb      <= r_first_y;
                        r_closing <= 1'b1;
                    end
                end
                S_PREP: begin
                    r_den <= (w_area_ext <<< 1) + w_area_ext;
                    r_res.centroid_x <= '0;
                    r_res.centroid_y <= '0;
                    r_res.status     <= pgc_pkg::ST_ZERO_AREA;
                end
                S_WX: begin
                    if (w_div_done) begin
                        r_res.centroid_x <= w_div_quo;
                    end
                end
                S_WY: begin
                    if (w_div_done) begin
                        r_res.centroid_y <= w_div_quo;
                        r_res.status     <= pgc_pkg::ST_OK;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out       <= r_res;
                        r_cnt       <= '0;
                        r_first_x   <= '0;
                        r_first_y   <= '0;
                        r_prev_x    <= '0;
                        r_prev_y    <= '0;
                        r_area      <= '0;
                        r_wsx       <= '0;
                        r_wsy       <= '0;
                        r_last      <= 1'b0;
                        r_closing   <= 1'b0;
                    end
                end
                default: begin
                    r_closing <= r_closing;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_IMP(a_out_from_done, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state) == S_DONE, "output valid rose outside the done state")
    `ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, (r_state == S_DONE) && w_out_free, o_out_valid && (r_state == S_IDLE), "finished result was not moved to the output register")
    `ASSERT_IMP(a_clear_idle, i_clk, i_rst_n, (r_state == S_IDLE) && (r_cnt == '0), (r_area == '0) && (r_wsx == '0) && (r_wsy == '0), "sums not cleared before a new polygon")
    `ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= pgc_pkg::CNT_W'(pgc_pkg::MAX_VERTICES + 1), "vertex count beyond its saturation value")

endmodule

/* tb/tb_polygon_centroid.sv */
// Self-checking testbench for the streaming polygon centroid block.
`timescale 1ns / 100ps

module tb_polygon_centroid;
    import pgc_pkg::*;

    localparam int unsigned IDLE_LIMIT  = 20000;
    localparam int unsigned HOLD_CYCLES = 1500;
    localparam int unsigned TAIL_CYCLES = 200;
    localparam int unsigned RANDOM_ITEMS = 1875;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_stall;
    t_in   i_in_data;
    logic  o_out_valid;
    logic  i_out_stall;
    t_out  o_out_data;

    polygon_centroid i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    t_in         vertex_feed[$];
    t_out        centroid_due[$];
    int unsigned total_items;
    int unsigned accepted_in;
    int unsigned mismatch_count;
    int unsigned idle_cycles;
    int unsigned gap_left;
    int unsigned stall_left;
    bit          in_fire;
    bit          hold_off;
    bit          calm_in;
    bit          calm_out;

    // Running shoelace state of the polygon being received.
    longint      first_x, first_y, last_x, last_y;
    longint      sum_wx, sum_wy, area2;
    int unsigned vtx_count;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint grid(logic [XY_W-1:0] raw);
        logic signed [XY_W-1:0] s;
        s = raw << (XY_W - CB);
        s = s >>> (XY_W - CB);
        return longint'(s);
    endfunction

    function automatic logic signed [XY_W-1:0] clamp(longint v);
        if (v > longint'(OUT_HI)) return OUT_HI;
        if (v < longint'(OUT_LO)) return OUT_LO;
        return v[XY_W-1:0];
    endfunction

    function automatic void add_edge(longint xa, longint ya, longint xb, longint yb);
        longint c;
        c = xa * yb - xb * ya;
        area2  += c;
        sum_wx += (xa + xb) * c;
        sum_wy += (ya + yb) * c;
    endfunction

    function automatic void take_vertex(t_in v);
        longint x, y, den;
        t_out   r;
        x = grid(v.vertex_x);
        y = grid(v.vertex_y);
        if (vtx_count == 0) begin
            first_x = x;
            first_y = y;
            vtx_count = 1;
        end else if (vtx_count < MAX_VERTICES) begin
            add_edge(last_x, last_y, x, y);
            vtx_count++;
        end else begin
            vtx_count = MAX_VERTICES + 1;
        end
        last_x = x;
        last_y = y;
        if (!v.last_vertex) return;

        r = '0;
        if (vtx_count > MAX_VERTICES) begin
            r.status = ST_OVERFLOW;
        end else if (vtx_count == 1) begin
            r.centroid_x = clamp(x);
            r.centroid_y = clamp(y);
            r.status = ST_SINGLE;
        end else begin
            add_edge(x, y, first_x, first_y);
            if (area2 == 0) begin
                r.status = ST_ZERO_AREA;
            end else begin
                den = 3 * area2;
                r.centroid_x = clamp(sum_wx / den);
                r.centroid_y = clamp(sum_wy / den);
                r.status = ST_OK;
            end
        end
        centroid_due.push_back(r);
        first_x = 0; first_y = 0; last_x = 0; last_y = 0;
        sum_wx = 0; sum_wy = 0; area2 = 0;
        vtx_count = 0;
    endfunction

    task automatic flag_mismatch(string msg);
        mismatch_count++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task automatic check_result(t_out got);
        t_out want;
        if (centroid_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected result x=%0d y=%0d status=%0d",
                got.centroid_x, got.centroid_y, got.status));
            return;
        end
        want = centroid_due.pop_front();
        if (got.centroid_x !== want.centroid_x)
            flag_mismatch($sformatf("centroid_x got %0d want %0d",
                got.centroid_x, want.centroid_x));
        if (got.centroid_y !== want.centroid_y)
            flag_mismatch($sformatf("centroid_y got %0d want %0d",
                got.centroid_y, want.centroid_y));
        if (got.status !== want.status)
            flag_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    endtask

    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_vertex(int x, int y, bit last);
        t_in v;
        v.vertex_x = x[XY_W-1:0];
        v.vertex_y = y[XY_W-1:0];
        v.last_vertex = last;
        vertex_feed.push_back(v);
    endtask

    function automatic int any_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    task automatic queue_polygon(int unsigned n);
        int unsigned shape;
        int cx, cy, dx, dy, x1, y1, x, y;
        shape = $urandom_range(0, 9);
        cx = any_coord();
        cy = any_coord();
        x1 = any_coord();
        y1 = any_coord();
        dx = int'($urandom_range(0, 6)) - 3;
        dy = int'($urandom_range(0, 6)) - 3;
        if (shape == 9) n = 4;
        for (int unsigned k = 0; k < n; k++) begin
            case (shape)
                5, 6: begin
                    x = cx + int'($urandom_range(0, 15)) - 8;
                    y = cy + int'($urandom_range(0, 15)) - 8;
                end
                7: begin
                    x = cx + int'(k) * dx;
                    y = cy + int'(k) * dy;
                end
                8: begin
                    x = cx;
                    y = cy;
                end
                9: begin
                    x = (k == 1 || k == 2) ? x1 : cx;
                    y = (k >= 2) ? y1 : cy;
                end
                default: begin
                    x = any_coord();
                    y = any_coord();
                end
            endcase
            queue_vertex(x, y, k == n - 1);
        end
    endtask

    task automatic fill_stimulus();
        int unsigned r, n, queued;
        // Single vertices at the extremes and the origin, then a two-vertex polygon.
        queue_vertex(-32768, 32767, 1'b1);
        queue_vertex(32767, -32768, 1'b1);
        queue_vertex(0, 0, 1'b1);
        queue_vertex(100, 200, 1'b0);
        queue_vertex(-300, 50, 1'b1);
        // Triangles of both orientations, one spanning the whole grid.
        queue_vertex(0, 0, 1'b0);
        queue_vertex(3000, 0, 1'b0);
        queue_vertex(0, 3000, 1'b1);
        queue_vertex(0, 0, 1'b0);
        queue_vertex(0, -3000, 1'b0);
        queue_vertex(-3000, 0, 1'b1);
        queue_vertex(-32768, -32768, 1'b0);
        queue_vertex(32767, -32768, 1'b0);
        queue_vertex(32767, 32767, 1'b1);
        // Collinear vertices enclose no area.
        queue_vertex(1, 1, 1'b0);
        queue_vertex(2, 2, 1'b0);
        queue_vertex(5, 5, 1'b1);
        // Nearly cancelling crossed quads push the centroid into saturation.
        queue_vertex(-32768, -32768, 1'b0);
        queue_vertex(32767, 32767, 1'b0);
        queue_vertex(32767, -32767, 1'b0);
        queue_vertex(-32768, 32767, 1'b1);
        queue_vertex(32767, -32768, 1'b0);
        queue_vertex(-32768, 32767, 1'b0);
        queue_vertex(-32768, -32767, 1'b0);
        queue_vertex(32767, 32767, 1'b1);

        queued = 0;
        while (queued < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 5) n = 1;
            else if (r < 10) n = 2;
            else if (r < 75) n = $urandom_range(3, 6);
            else if (r < 95) n = $urandom_range(7, 16);
            else n = $urandom_range(17, 60);
            r = vertex_feed.size();
            queue_polygon(n);
            queued += vertex_feed.size() - r;
        end
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (vertex_feed.size() > 0) begin
                i_in_data <= vertex_feed.pop_front();
                i_in_valid <= 1'b1;
                if ($urandom_range(0, 199) == 0) calm_in = !calm_in;
                gap_left = pick_gap(calm_in);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                if ($urandom_range(0, 199) == 0) calm_out = !calm_out;
                stall_left = pick_gap(calm_out);
                i_out_stall <= hold_off;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_fire <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                accepted_in++;
                take_vertex(i_in_data);
            end
            if (o_out_valid && !i_out_stall) check_result(o_out_data);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // The receiver holds off for a long stretch so that the block backs up.
    initial begin
        hold_off = 1'b0;
        while (accepted_in < 300) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        in_fire = 1'b0;
        calm_in = 1'b0;
        calm_out = 1'b0;
        gap_left = 0;
        stall_left = 0;
        accepted_in = 0;
        mismatch_count = 0;
        idle_cycles = 0;
        first_x = 0; first_y = 0; last_x = 0; last_y = 0;
        sum_wx = 0; sum_wy = 0; area2 = 0;
        vtx_count = 0;
        fill_stimulus();
        total_items = vertex_feed.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_in < total_items) @(posedge i_clk);
        while (centroid_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
